FILE: design/iaht_pkg.sv
// ----------------------------------------------------------------------------
// iaht_pkg
// Shared constants for the image access hazard tracker: configuration
// register indexes and the width of the register index.
// ----------------------------------------------------------------------------
`default_nettype none

package iaht_pkg;

    localparam int CFG_IDX_BITS = 1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_WRITE_CLASS = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_READ_CLASS  = 1'b1;

endpackage

`default_nettype wire

FILE: design/image_access_hazard_tracker.sv
// ----------------------------------------------------------------------------
// image_access_hazard_tracker
// Decides, per access request to one image, whether a pipeline barrier is
// needed and with which source and destination masks and layouts.
//
// Usage:
//   Request channel (i_valid / o_ready) carries kind, stage mask, access
//   mask and layout. Kind 1 drains the history (layout is kept).
//   Result channel (o_valid / i_ready) returns one result per request, in
//   order. When no barrier is needed all result fields are zero.
//   Configuration: i_cfg_we writes the write-class mask (index 0) or the
//   read-class mask (index 1). Write only while no request is in flight.
//   Path: a request passes the input register, then the result register;
//   the history updates as it moves between the two. Throughput: one
//   request per cycle while the result register is not stalled by i_ready.
//   Stall: with i_ready low the result register holds; one more request
//   waits in the input register, then o_ready drops.
//   Reset: clears both masks, the history (no prior access, layout 0) and
//   all valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module image_access_hazard_tracker #(
    parameter int STAGE_BITS  = 32,
    parameter int ACCESS_BITS = 32,
    parameter int LAYOUT_BITS = 4
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [iaht_pkg::CFG_IDX_BITS-1:0] i_cfg_addr,
    input  wire logic [ACCESS_BITS-1:0]            i_cfg_wdata,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic                              i_kind,
    input  wire logic [STAGE_BITS-1:0]             i_req_stages,
    input  wire logic [ACCESS_BITS-1:0]            i_req_access,
    input  wire logic [LAYOUT_BITS-1:0]            i_req_layout,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic                                   o_barrier_needed,
    output logic      [STAGE_BITS-1:0]             o_src_stage_mask,
    output logic      [ACCESS_BITS-1:0]            o_src_access_mask,
    output logic      [STAGE_BITS-1:0]             o_dst_stage_mask,
    output logic      [ACCESS_BITS-1:0]            o_dst_access_mask,
    output logic      [LAYOUT_BITS-1:0]            o_old_layout_code,
    output logic      [LAYOUT_BITS-1:0]            o_new_layout_code
);

    logic [ACCESS_BITS-1:0] write_class_mask;
    logic [ACCESS_BITS-1:0] read_class_mask;

    logic                   r_s1_valid;
    logic                   r_s1_kind;
    logic [STAGE_BITS-1:0]  r_s1_stages;
    logic [ACCESS_BITS-1:0] r_s1_access;
    logic [LAYOUT_BITS-1:0] r_s1_layout;

    logic                   r_out_valid;
    logic                   r_barrier;
    logic [STAGE_BITS-1:0]  r_src_stage;
    logic [ACCESS_BITS-1:0] r_src_access;
    logic [STAGE_BITS-1:0]  r_dst_stage;
    logic [ACCESS_BITS-1:0] r_dst_access;
    logic [LAYOUT_BITS-1:0] r_old_layout;
    logic [LAYOUT_BITS-1:0] r_new_layout;

    logic                   s1_advance;
    logic                   commit;
    logic                   n_barrier;
    logic [STAGE_BITS-1:0]  n_src_stage;
    logic [ACCESS_BITS-1:0] n_src_access;
    logic [STAGE_BITS-1:0]  n_dst_stage;
    logic [ACCESS_BITS-1:0] n_dst_access;
    logic [LAYOUT_BITS-1:0] n_old_layout;
    logic [LAYOUT_BITS-1:0] n_new_layout;

    assign s1_advance = !r_out_valid || i_ready;
    assign commit     = r_s1_valid && s1_advance;
    assign o_ready    = !r_s1_valid || s1_advance;

    iaht_cfg_regs #(
        .ACCESS_BITS (ACCESS_BITS)
    ) u_cfg (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_addr         (i_cfg_addr),
        .i_cfg_wdata        (i_cfg_wdata),
        .o_write_class_mask (write_class_mask),
        .o_read_class_mask  (read_class_mask)
    );

    iaht_hazard_core #(
        .STAGE_BITS  (STAGE_BITS),
        .ACCESS_BITS (ACCESS_BITS),
        .LAYOUT_BITS (LAYOUT_BITS)
    ) u_core (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_commit           (commit),
        .i_kind             (r_s1_kind),
        .i_req_stages       (r_s1_stages),
        .i_req_access       (r_s1_access),
        .i_req_layout       (r_s1_layout),
        .i_write_class_mask (write_class_mask),
        .i_read_class_mask  (read_class_mask),
        .o_barrier_needed   (n_barrier),
        .o_src_stage_mask   (n_src_stage),
        .o_src_access_mask  (n_src_access),
        .o_dst_stage_mask   (n_dst_stage),
        .o_dst_access_mask  (n_dst_access),
        .o_old_layout_code  (n_old_layout),
        .o_new_layout_code  (n_new_layout)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
            if (s1_advance) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_s1_kind   <= i_kind;
            r_s1_stages <= i_req_stages;
            r_s1_access <= i_req_access;
            r_s1_layout <= i_req_layout;
        end
        if (commit) begin
            r_barrier    <= n_barrier;
            r_src_stage  <= n_src_stage;
            r_src_access <= n_src_access;
            r_dst_stage  <= n_dst_stage;
            r_dst_access <= n_dst_access;
            r_old_layout <= n_old_layout;
            r_new_layout <= n_new_layout;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_barrier_needed  = r_barrier;
    assign o_src_stage_mask  = r_src_stage;
    assign o_src_access_mask = r_src_access;
    assign o_dst_stage_mask  = r_dst_stage;
    assign o_dst_access_mask = r_dst_access;
    assign o_old_layout_code = r_old_layout;
    assign o_new_layout_code = r_new_layout;

endmodule

`default_nettype wire

FILE: design/iaht_cfg_regs.sv
// ----------------------------------------------------------------------------
// iaht_cfg_regs
// Access class mask registers: which access bits count as memory writes
// and which count as memory reads.
// ----------------------------------------------------------------------------
`default_nettype none

module iaht_cfg_regs #(
    parameter int ACCESS_BITS = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [iaht_pkg::CFG_IDX_BITS-1:0] i_cfg_addr,
    input  wire logic [ACCESS_BITS-1:0]            i_cfg_wdata,
    output logic      [ACCESS_BITS-1:0]            o_write_class_mask,
    output logic      [ACCESS_BITS-1:0]            o_read_class_mask
);

    logic [ACCESS_BITS-1:0] r_write_class_mask;
    logic [ACCESS_BITS-1:0] r_read_class_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_class_mask <= '0;
            r_read_class_mask  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                iaht_pkg::CFG_WRITE_CLASS: r_write_class_mask <= i_cfg_wdata;
                iaht_pkg::CFG_READ_CLASS:  r_read_class_mask  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_write_class_mask = r_write_class_mask;
    assign o_read_class_mask  = r_read_class_mask;

endmodule

`default_nettype wire

FILE: design/iaht_hazard_core.sv
// ----------------------------------------------------------------------------
// iaht_hazard_core
// Access history of one image and the barrier decision for one request.
// The decision is combinational on the current history; the history
// advances when the request is committed.
// ----------------------------------------------------------------------------
`default_nettype none

module iaht_hazard_core #(
    parameter int STAGE_BITS  = 32,
    parameter int ACCESS_BITS = 32,
    parameter int LAYOUT_BITS = 4
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_commit,
    input  wire logic                   i_kind,
    input  wire logic [STAGE_BITS-1:0]  i_req_stages,
    input  wire logic [ACCESS_BITS-1:0] i_req_access,
    input  wire logic [LAYOUT_BITS-1:0] i_req_layout,
    input  wire logic [ACCESS_BITS-1:0] i_write_class_mask,
    input  wire logic [ACCESS_BITS-1:0] i_read_class_mask,
    output logic                        o_barrier_needed,
    output logic      [STAGE_BITS-1:0]  o_src_stage_mask,
    output logic      [ACCESS_BITS-1:0] o_src_access_mask,
    output logic      [STAGE_BITS-1:0]  o_dst_stage_mask,
    output logic      [ACCESS_BITS-1:0] o_dst_access_mask,
    output logic      [LAYOUT_BITS-1:0] o_old_layout_code,
    output logic      [LAYOUT_BITS-1:0] o_new_layout_code
);

    typedef enum logic [1:0] {
        PH_NONE  = 2'd0,
        PH_READ  = 2'd1,
        PH_WRITE = 2'd2,
        PH_RAW   = 2'd3
    } t_phase;

    t_phase                 r_phase,        n_phase;
    logic [STAGE_BITS-1:0]  r_first_stages, n_first_stages;
    logic [ACCESS_BITS-1:0] r_first_access, n_first_access;
    logic [LAYOUT_BITS-1:0] r_layout,       n_layout;
    logic [STAGE_BITS-1:0]  r_rd_stages,    n_rd_stages;
    logic [ACCESS_BITS-1:0] r_rd_access,    n_rd_access;

    logic layout_change;
    logic is_write;
    logic is_read;

    assign layout_change = (i_req_layout != r_layout);
    assign is_write      = (|(i_req_access & i_write_class_mask)) || layout_change;
    assign is_read       = |(i_req_access & i_read_class_mask);

    always_comb begin
        n_phase           = r_phase;
        n_first_stages    = r_first_stages;
        n_first_access    = r_first_access;
        n_layout          = r_layout;
        n_rd_stages       = r_rd_stages;
        n_rd_access       = r_rd_access;
        o_barrier_needed  = 1'b0;
        o_src_stage_mask  = '0;
        o_src_access_mask = '0;
        o_dst_stage_mask  = '0;
        o_dst_access_mask = '0;
        o_old_layout_code = '0;
        o_new_layout_code = '0;

        if (i_kind) begin
            n_phase        = PH_NONE;
            n_first_stages = '0;
            n_first_access = '0;
        end else if (is_write) begin
            unique case (r_phase)
                PH_NONE: begin
                    o_barrier_needed = layout_change;
                end
                PH_READ, PH_WRITE: begin
                    o_barrier_needed  = 1'b1;
                    o_src_stage_mask  = r_first_stages;
                    o_src_access_mask = r_first_access;
                end
                PH_RAW: begin
                    o_barrier_needed  = 1'b1;
                    o_src_stage_mask  = r_rd_stages;
                    o_src_access_mask = r_rd_access;
                end
            endcase
            if (o_barrier_needed) begin
                o_dst_stage_mask  = i_req_stages;
                o_dst_access_mask = i_req_access;
                o_old_layout_code = r_layout;
                o_new_layout_code = i_req_layout;
            end
            if (r_phase != PH_NONE) begin
                n_rd_stages = '0;
                n_rd_access = '0;
            end
            n_phase        = PH_WRITE;
            n_first_stages = i_req_stages;
            n_first_access = i_req_access;
            n_layout       = i_req_layout;
        end else if (is_read) begin
            unique case (r_phase)
                PH_NONE: begin
                    n_phase        = PH_READ;
                    n_first_stages = i_req_stages;
                    n_first_access = i_req_access;
                end
                PH_READ: begin
                    n_first_stages = r_first_stages | i_req_stages;
                    n_first_access = r_first_access | i_req_access;
                end
                PH_WRITE: begin
                    n_phase     = PH_RAW;
                    n_rd_stages = i_req_stages;
                    n_rd_access = i_req_access;
                end
                PH_RAW: begin
                    n_rd_stages = r_rd_stages | i_req_stages;
                    n_rd_access = r_rd_access | i_req_access;
                end
            endcase
            if ((r_phase == PH_WRITE) || (r_phase == PH_RAW)) begin
                o_barrier_needed  = 1'b1;
                o_src_stage_mask  = r_first_stages;
                o_src_access_mask = r_first_access;
                o_dst_stage_mask  = i_req_stages;
                o_dst_access_mask = i_req_access;
                o_old_layout_code = r_layout;
                o_new_layout_code = r_layout;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_NONE;
            r_first_stages <= '0;
            r_first_access <= '0;
            r_layout       <= '0;
            r_rd_stages    <= '0;
            r_rd_access    <= '0;
        end else if (i_commit) begin
            r_phase        <= n_phase;
            r_first_stages <= n_first_stages;
            r_first_access <= n_first_access;
            r_layout       <= n_layout;
            r_rd_stages    <= n_rd_stages;
            r_rd_access    <= n_rd_access;
        end
    end

endmodule

`default_nettype wire

FILE: design/iaht_checker.sv
// ----------------------------------------------------------------------------
// iaht_checker
// Port-level checks for the image access hazard tracker, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module iaht_checker #(
    parameter int STAGE_BITS  = 32,
    parameter int ACCESS_BITS = 32,
    parameter int LAYOUT_BITS = 4
) (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   o_ready,
    input wire logic                   o_valid,
    input wire logic                   i_ready,
    input wire logic                   o_barrier_needed,
    input wire logic [STAGE_BITS-1:0]  o_src_stage_mask,
    input wire logic [ACCESS_BITS-1:0] o_src_access_mask,
    input wire logic [STAGE_BITS-1:0]  o_dst_stage_mask,
    input wire logic [ACCESS_BITS-1:0] o_dst_access_mask,
    input wire logic [LAYOUT_BITS-1:0] o_old_layout_code,
    input wire logic [LAYOUT_BITS-1:0] o_new_layout_code
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("result valid or not ready after reset");

    a_no_barrier_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_barrier_needed |->
            (o_src_stage_mask == '0) && (o_src_access_mask == '0) &&
            (o_dst_stage_mask == '0) && (o_dst_access_mask == '0) &&
            (o_old_layout_code == '0) && (o_new_layout_code == '0))
        else $error("fields set without a barrier");

    a_ready_when_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty result register");

endmodule

bind image_access_hazard_tracker iaht_checker #(
    .STAGE_BITS  (STAGE_BITS),
    .ACCESS_BITS (ACCESS_BITS),
    .LAYOUT_BITS (LAYOUT_BITS)
) u_iaht_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_ready           (o_ready),
    .o_valid           (o_valid),
    .i_ready           (i_ready),
    .o_barrier_needed  (o_barrier_needed),
    .o_src_stage_mask  (o_src_stage_mask),
    .o_src_access_mask (o_src_access_mask),
    .o_dst_stage_mask  (o_dst_stage_mask),
    .o_dst_access_mask (o_dst_access_mask),
    .o_old_layout_code (o_old_layout_code),
    .o_new_layout_code (o_new_layout_code)
);

`default_nettype wire
